// ===== sv/fqs_pkg.sv =====
package fqs_pkg;

  // Operation codes as they arrive on the input channel.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Position reported when nothing was found or the operation is not a search.
  localparam logic [4:0] POS_NONE = 5'h1F;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_REMOVE,
    KIND_SEARCH,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] position;
    logic [4:0] count;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_SRCH
  } state_t;

endpackage

// ===== sv/fqs_front.sv =====
module fqs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output fqs_pkg::cmd_t      cmd
);

  fqs_pkg::cmd_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  fqs_pkg::cmd_t dec;

  // Classify the operation code before it is queued.
  always_comb begin
    dec.value = in_value;
    case (in_op)
      fqs_pkg::OP_INSERT: dec.kind = fqs_pkg::KIND_INSERT;
      fqs_pkg::OP_REMOVE: dec.kind = fqs_pkg::KIND_REMOVE;
      fqs_pkg::OP_SEARCH: dec.kind = fqs_pkg::KIND_SEARCH;
      default:            dec.kind = fqs_pkg::KIND_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== sv/fqs_exec.sv =====
module fqs_exec #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  fqs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output fqs_pkg::res_t res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [31:0] store_r [DEPTH];

  fqs_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]      chk_pos_r, chk_pos_nxt;
  logic signed [31:0] rdata_r;
  logic               out_vld_r, out_vld_nxt;
  fqs_pkg::res_t      out_res_r, out_res_nxt;

  logic out_free, take, wr_en, rd_load;
  logic hit, last, fin, stall;
  logic emit;
  fqs_pkg::res_t emit_res;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    ring_next = (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  assign out_free  = !out_vld_r || res_ready;
  assign cmd_ready = (state_r == fqs_pkg::ST_IDLE) && out_free;
  assign take      = cmd_valid && cmd_ready;

  // The compare stage works on each read in the cycle after the read stage issues it.
  assign hit   = chk_vld_r && (rdata_r == key_r);
  assign last  = chk_vld_r && (chk_pos_r == cnt_r - CW'(1));
  assign fin   = hit || last;
  assign stall = fin && !out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fqs_pkg::ST_IDLE: begin
        if (take && cmd.kind == fqs_pkg::KIND_SEARCH && cnt_r != '0) begin
          state_nxt = fqs_pkg::ST_SRCH;
        end
      end
      fqs_pkg::ST_SRCH: begin
        if (fin && !stall) begin
          state_nxt = fqs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    key_nxt     = key_r;
    rd_idx_nxt  = rd_idx_r;
    rd_cnt_nxt  = rd_cnt_r;
    chk_vld_nxt = chk_vld_r;
    chk_pos_nxt = chk_pos_r;
    wr_en       = 1'b0;
    rd_load     = 1'b0;
    emit        = 1'b0;
    emit_res.ok       = 1'b0;
    emit_res.position = fqs_pkg::POS_NONE;
    emit_res.count    = 5'(cnt_r);
    case (state_r)
      fqs_pkg::ST_IDLE: begin
        if (take) begin
          case (cmd.kind)
            fqs_pkg::KIND_INSERT: begin
              emit = 1'b1;
              if (cnt_r != FULL_CNT) begin
                wr_en          = 1'b1;
                tail_nxt       = ring_next(tail_r);
                cnt_nxt        = cnt_r + CW'(1);
                emit_res.ok    = 1'b1;
                emit_res.count = 5'(cnt_r + CW'(1));
              end
            end
            fqs_pkg::KIND_REMOVE: begin
              emit = 1'b1;
              if (cnt_r != '0) begin
                head_nxt       = ring_next(head_r);
                cnt_nxt        = cnt_r - CW'(1);
                emit_res.ok    = 1'b1;
                emit_res.count = 5'(cnt_r - CW'(1));
              end
            end
            fqs_pkg::KIND_SEARCH: begin
              if (cnt_r == '0) begin
                emit = 1'b1;
              end else begin
                key_nxt     = cmd.value;
                rd_idx_nxt  = head_r;
                rd_cnt_nxt  = '0;
                chk_vld_nxt = 1'b0;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      fqs_pkg::ST_SRCH: begin
        if (!stall) begin
          if (fin) begin
            emit        = 1'b1;
            chk_vld_nxt = 1'b0;
            if (hit) begin
              emit_res.ok       = 1'b1;
              emit_res.position = 5'(chk_pos_r);
            end
          end else if (rd_cnt_r != cnt_r) begin
            rd_load     = 1'b1;
            chk_vld_nxt = 1'b1;
            chk_pos_nxt = rd_cnt_r;
            rd_cnt_nxt  = rd_cnt_r + CW'(1);
            rd_idx_nxt  = ring_next(rd_idx_r);
          end else begin
            chk_vld_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_res_nxt = out_res_r;
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
      out_res_nxt = emit_res;
    end else if (res_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fqs_pkg::ST_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      cnt_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      cnt_r     <= cnt_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    rd_idx_r  <= rd_idx_nxt;
    rd_cnt_r  <= rd_cnt_nxt;
    chk_pos_r <= chk_pos_nxt;
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[tail_r] <= cmd.value;
    end
    if (rd_load) begin
      rdata_r <= store_r[rd_idx_r];
    end
  end

  assign res_valid = out_vld_r;
  assign res       = out_res_r;

endmodule

// ===== sv/fifo_queue_with_search.sv =====
// Channel | Ports          | Payload from bit 0 up
// input   | in_t*          | op[1:0], value[33:2], zero fill to 40 bits
// result  | out_t*         | ok[0], position[5:1], count[10:6], zero fill to 16 bits
//
// Insert, remove, unused codes and a search of an empty queue finish in the cycle after the
// command leaves the input queue. Any other search stays in the executer while it reads entries
// from the head until a hit or the whole count is read, since the ring store has one registered
// read port read once per cycle.
// rst_n is synchronous and active low; it empties the queue and both channel stages.
// A two-entry input queue takes up to two transfers while the executer works or the result waits.
module fifo_queue_with_search #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[1:0], value[33:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // ok[0], position[5:1], count[10:6]
);

  logic          cmd_valid, cmd_ready;
  fqs_pkg::cmd_t cmd;
  fqs_pkg::res_t res;

  fqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_value  (in_tdata[33:2]),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fqs_exec #(
    .DEPTH (DEPTH)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {5'd0, res.count, res.position, res.ok};

  // A failed operation never reports a position.
  a_fail_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[5:1] == fqs_pkg::POS_NONE))
    else $error("failed result carries a position");

  // The input side only backs up when the command queue is holding work.
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> cmd_valid)
    else $error("input stalled with an empty command queue");

  // The reported count never goes past the ring size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((DEPTH > 31) || (out_tdata[10:6] <= 5'(DEPTH))))
    else $error("count beyond queue depth");

  // A hit position always lies below the count held.
  a_pos_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0] && out_tdata[5:1] != fqs_pkg::POS_NONE && DEPTH < 32)
      |-> (out_tdata[5:1] < out_tdata[10:6]))
    else $error("search hit outside the held entries");

endmodule

// ===== tb/tb_fifo_queue_with_search.sv =====
module tb_fifo_queue_with_search;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  // Reserved operation code; the block answers it without touching the queue.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]    op;
    logic [31:0]   value;
    logic          fixed;  // 1: want holds the expected result, 0: use the queue predictor
    fqs_pkg::res_t want;
  } row_t;

  localparam int ROWS = 27;
  localparam row_t SCRIPT [ROWS] = '{
    '{fqs_pkg::OP_SEARCH, 32'h0000_0000, 1'b1, '{1'b0, fqs_pkg::POS_NONE, 5'd0}},
    '{fqs_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{1'b0, fqs_pkg::POS_NONE, 5'd0}},
    '{OP_UNUSED,          32'hFFFF_FFFF, 1'b1, '{1'b0, fqs_pkg::POS_NONE, 5'd0}},
    '{fqs_pkg::OP_INSERT, 32'h8000_0000, 1'b1, '{1'b1, fqs_pkg::POS_NONE, 5'd1}},
    '{fqs_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{1'b1, fqs_pkg::POS_NONE, 5'd2}},
    '{fqs_pkg::OP_INSERT, 32'h0000_0000, 1'b1, '{1'b1, fqs_pkg::POS_NONE, 5'd3}},
    '{fqs_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b1, '{1'b1, fqs_pkg::POS_NONE, 5'd4}},
    '{fqs_pkg::OP_SEARCH, 32'h7FFF_FFFF, 1'b1, '{1'b1, 5'd1, 5'd4}},
    '{fqs_pkg::OP_SEARCH, 32'h8000_0000, 1'b1, '{1'b1, 5'd0, 5'd4}},
    '{fqs_pkg::OP_SEARCH, 32'hFFFF_FFFF, 1'b1, '{1'b1, 5'd3, 5'd4}},
    '{fqs_pkg::OP_SEARCH, 32'h0000_0005, 1'b1, '{1'b0, fqs_pkg::POS_NONE, 5'd4}},
    '{fqs_pkg::OP_INSERT, 32'h0000_0001, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'hFFFF_FFFE, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h5555_5555, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h0000_0000, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h1234_5678, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h8000_0001, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h7FFF_FFFE, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h0F0F_0F0F, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'hF0F0_F0F0, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h0000_0100, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h3C3C_3C3C, 1'b0, '0},
    '{fqs_pkg::OP_INSERT, 32'h2468_ACE0, 1'b1, '{1'b0, fqs_pkg::POS_NONE, 5'd16}},
    '{fqs_pkg::OP_SEARCH, 32'h3C3C_3C3C, 1'b0, '0},
    '{fqs_pkg::OP_REMOVE, 32'h0000_0000, 1'b1, '{1'b1, fqs_pkg::POS_NONE, 5'd15}},
    '{fqs_pkg::OP_SEARCH, 32'h0000_0000, 1'b0, '0}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // op[1:0], value[33:2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // ok[0], position[5:1], count[10:6]

  // Shadow copy of the ring and the results still owed by the block.
  logic [31:0]   ring_copy [DEPTH];
  int            ring_head     = 0;
  int            ring_tail     = 0;
  int            ring_count    = 0;
  fqs_pkg::res_t pending_results [$];

  int          errors        = 0;
  int          results_seen  = 0;
  int          cycle_count   = 0;
  bit          gaps_on       = 1'b1;

  fifo_queue_with_search #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic fqs_pkg::res_t apply_queue_op(input logic [1:0] op,
                                                   input logic [31:0] value);
    fqs_pkg::res_t r;
    int            idx;
    r.ok       = 1'b0;
    r.position = fqs_pkg::POS_NONE;
    case (op)
      fqs_pkg::OP_INSERT: begin
        if (ring_count < DEPTH) begin
          ring_copy[ring_tail] = value;
          ring_tail            = (ring_tail + 1) % DEPTH;
          ring_count++;
          r.ok = 1'b1;
        end
      end
      fqs_pkg::OP_REMOVE: begin
        if (ring_count > 0) begin
          ring_head = (ring_head + 1) % DEPTH;
          ring_count--;
          r.ok = 1'b1;
        end
      end
      fqs_pkg::OP_SEARCH: begin
        idx = ring_head;
        for (int i = 0; i < ring_count; i++) begin
          // Only the first match from the head counts.
          if (!r.ok && ring_copy[idx] == value) begin
            r.ok       = 1'b1;
            r.position = 5'(i);
          end
          idx = (idx + 1) % DEPTH;
        end
      end
      default: ;
    endcase
    r.count = 5'(ring_count);
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(input logic [1:0] op, input logic [31:0] value,
                          input logic fixed, input fqs_pkg::res_t want);
    fqs_pkg::res_t r;
    while (gaps_on && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, value, op};
    do @(posedge clk); while (!in_tready);
    r = apply_queue_op(op, value);
    pending_results.push_back(fixed ? want : r);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [1:0]  op;
    logic [31:0] value;
    int          pick;
    int          mode_left;
    bit          fill_bias;
    mode_left = 0;
    fill_bias = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < ROWS; k++) begin
      send_cmd(SCRIPT[k].op, SCRIPT[k].value, SCRIPT[k].fixed, SCRIPT[k].want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Alternate between filling and draining so both full and empty are reached often.
      if (mode_left == 0) begin
        fill_bias = !fill_bias;
        mode_left = $urandom_range(60, 20);
      end
      mode_left--;
      gaps_on = !(n >= 300 && n < 500);

      pick = $urandom_range(99);
      if (pick < 3)
        op = OP_UNUSED;
      else if (pick < 30)
        op = fqs_pkg::OP_SEARCH;
      else if (pick < (fill_bias ? 80 : 45))
        op = fqs_pkg::OP_INSERT;
      else
        op = fqs_pkg::OP_REMOVE;

      case ($urandom_range(3))
        0: value = $urandom;
        1: value = $urandom_range(7);
        default: begin
          if (ring_count != 0)
            value = ring_copy[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
          else
            value = $urandom;
        end
      endcase
      send_cmd(op, value, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Result side: random back-pressure plus one long hold-off that fills the block.
  initial begin : result_sink
    int hold;
    bit held_once;
    hold      = 0;
    held_once = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && results_seen >= 150) begin
        held_once = 1'b1;
        hold      = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 10);
      end
    end
  end

  always @(posedge clk) begin : result_check
    fqs_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[0] !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_tdata[0]);
          errors++;
        end
        if (out_tdata[5:1] !== want.position) begin
          $error("position: expected %0d, got %0d",
                 $signed(want.position), $signed(out_tdata[5:1]));
          errors++;
        end
        if (out_tdata[10:6] !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_tdata[10:6]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
sv/fqs_pkg.sv
sv/fqs_front.sv
sv/fqs_exec.sv
sv/fifo_queue_with_search.sv
tb/tb_fifo_queue_with_search.sv
